// ===== rtl/core/cgmd_pkg.sv =====
package cgmd_pkg;

    localparam int LABEL_COUNT = 5;
    localparam int CFG_IDX_W   = 3;

    typedef logic [2:0] t_label;

    localparam t_label START_LABEL = 3'd3;
    localparam t_label LAST_LABEL  = 3'd4;

    localparam logic signed [15:0] NO_GESTURE = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTROID_FOUR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD      = 3'd6;

    localparam logic [31:0]        OFFSET_RESET    = 32'd175248822;
    localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5301;

    // one distance half-step request: centroid and which axis
    typedef struct packed {
        logic   vld;
        t_label k;
        logic   p;
    } t_label_req;

    typedef struct packed {
        logic   vld;
        t_label label;
    } t_label_wr;

    function automatic logic prob_ok(input t_label a, input t_label b);
        logic ok;
        case ({a, b})
            {3'd0, 3'd2}: ok = 1'b1;
            {3'd1, 3'd4}: ok = 1'b1;
            {3'd2, 3'd0}: ok = 1'b1;
            {3'd2, 3'd4}: ok = 1'b1;
            {3'd3, 3'd1}: ok = 1'b1;
            {3'd3, 3'd4}: ok = 1'b1;
            {3'd4, 3'd0}: ok = 1'b1;
            default:      ok = 1'b0;
        endcase
        return ok;
    endfunction

    // q7.8 natural log of the transition probability
    function automatic logic signed [15:0] log_prob(input t_label a, input t_label b);
        logic signed [15:0] v;
        case ({a, b})
            {3'd2, 3'd0}: v = -16'sd532;
            {3'd2, 3'd4}: v = -16'sd34;
            {3'd3, 3'd1}: v = -16'sd82;
            {3'd3, 3'd4}: v = -16'sd614;
            default:      v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/cgmd_ram.sv =====
module cgmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/cgmd_label.sv =====
module cgmd_label #(
    parameter int RUN_LEN = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cgmd_pkg::t_label_req              i_req,
    input  logic signed [16+$clog2(RUN_LEN)-1:0] i_sum,
    input  logic [31:0]                       i_centroid [cgmd_pkg::LABEL_COUNT],
    input  logic [31:0]                       i_offset,
    output cgmd_pkg::t_label_wr               o_wr
);

    import cgmd_pkg::*;

    localparam int SW  = 16 + $clog2(RUN_LEN);
    localparam int CW  = 17 + $clog2(RUN_LEN + 1);
    localparam int DW  = CW + 1;
    localparam int SQW = 2 * DW;

    localparam logic signed [CW-1:0] L_S = CW'(RUN_LEN);

    // stage a: centroid plus offset on one axis
    logic               r_a_vld;
    t_label             r_a_k;
    logic               r_a_p;
    logic signed [SW-1:0] r_a_sum;
    logic signed [16:0] r_a_cpo;

    // stage b: difference to the scaled centroid
    logic               r_b_vld;
    t_label             r_b_k;
    logic               r_b_p;
    logic signed [DW-1:0] r_b_diff;

    // stage c: square
    logic               r_c_vld;
    t_label             r_c_k;
    logic               r_c_p;
    logic [SQW-1:0]     r_c_sq;

    // stage d: distance and best so far
    logic [SQW-1:0]     r_dx2;
    logic [SQW:0]       r_best;
    t_label             r_bestk;
    logic               r_wr_vld;
    t_label             r_wr_label;

    logic [31:0]        c_sel;
    logic signed [15:0] c_h;
    logic signed [15:0] o_h;
    logic signed [16:0] cpo;
    logic signed [CW-1:0] cx;
    logic signed [DW-1:0] diff;
    logic signed [SQW-1:0] sq_full;
    logic [SQW:0]       dist_sum;
    logic               better;

    always_comb begin
        c_sel = i_centroid[i_req.k];
        c_h   = i_req.p ? signed'(c_sel[31:16]) : signed'(c_sel[15:0]);
        o_h   = i_req.p ? signed'(i_offset[31:16]) : signed'(i_offset[15:0]);
        cpo   = 17'(c_h) + 17'(o_h);
    end

    assign cx       = r_a_cpo * L_S;
    assign diff     = DW'(r_a_sum) - DW'(cx);
    assign sq_full  = r_b_diff * r_b_diff;
    assign dist_sum = {1'b0, r_dx2} + {1'b0, r_c_sq};
    assign better   = (r_c_k == '0) || (dist_sum < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_wr_vld  <= 1'b0;
        end else begin
            r_a_vld   <= i_req.vld;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_wr_vld  <= r_c_vld && r_c_p && (r_c_k == LAST_LABEL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_k    <= i_req.k;
        r_a_p    <= i_req.p;
        r_a_sum  <= i_sum;
        r_a_cpo  <= cpo;
        r_b_k    <= r_a_k;
        r_b_p    <= r_a_p;
        r_b_diff <= diff;
        r_c_k    <= r_b_k;
        r_c_p    <= r_b_p;
        r_c_sq   <= sq_full;
        r_wr_label <= better ? r_c_k : r_bestk;
        if (r_c_vld) begin
            if (!r_c_p) begin
                r_dx2 <= r_c_sq;
            end else if (better) begin
                r_best  <= dist_sum;
                r_bestk <= r_c_k;
            end
        end
    end

    assign o_wr = '{vld: r_wr_vld, label: r_wr_label};

endmodule

// ===== rtl/core/cgmd_score.sv =====
module cgmd_score #(
    parameter int RUN_COUNT = 5
) (
    input  cgmd_pkg::t_label   i_labels [RUN_COUNT],
    input  logic signed [15:0] i_threshold,
    output logic signed [15:0] o_like,
    output logic               o_found,
    output logic [14:0]        o_packed
);

    import cgmd_pkg::*;

    logic               ok;
    logic signed [18:0] acc;
    logic signed [15:0] like;

    always_comb begin
        ok  = (i_labels[0] == START_LABEL);
        acc = '0;
        for (int r = 1; r < RUN_COUNT; r++) begin
            if (!prob_ok(i_labels[r-1], i_labels[r])) begin
                ok = 1'b0;
            end else begin
                acc = acc + 19'(log_prob(i_labels[r-1], i_labels[r]));
            end
        end
        if (acc < -19'sd32767) begin
            like = -16'sd32767;
        end else if (acc > 19'sd32767) begin
            like = 16'sd32767;
        end else begin
            like = acc[15:0];
        end
        o_like  = ok ? like : NO_GESTURE;
        o_found = ok && (like > i_threshold);
    end

    always_comb begin
        o_packed = '0;
        for (int r = 0; r < RUN_COUNT && r < 5; r++) begin
            o_packed[3*r +: 3] = i_labels[r];
        end
    end

endmodule

// ===== rtl/core/circle_gesture_markov_detector.sv =====
// until the window is full, an accepted sample goes to S_SCORE, which registers the result once the output is free
// once it is full, S_ACC sums each run from the ring, S_LABEL labels the runs and S_SCORE scores them
// S_ACC issues one ring read per cycle; S_LABEL issues ten distance half-steps per run
// one item in work at a time: the next accept waits for S_IDLE
// a waiting result does not block the next accept
// synchronous active-low reset clears control, fill count and slot, and loads the configuration defaults
module circle_gesture_markov_detector #(
    parameter int WINDOW_LEN = 60,
    parameter int RUN_COUNT  = 5,
    parameter int RUN_LEN    = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [31:0]                    i_s_tdata,   // pos_x, pos_y
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [39:0]                    o_m_tdata,   // circle_found, window_full,
                                                        // log_likelihood, run_labels
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cgmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    import cgmd_pkg::*;

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam int RW = (RUN_COUNT > 1) ? $clog2(RUN_COUNT) : 1;
    localparam int JW = (RUN_LEN > 1) ? $clog2(RUN_LEN) : 1;
    localparam int SW = 16 + $clog2(RUN_LEN);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ACC   = 2'd1;
    localparam logic [1:0] S_LABEL = 2'd2;
    localparam logic [1:0] S_SCORE = 2'd3;

    logic [1:0]         r_state;
    logic [AW-1:0]      r_slot;
    logic [AW-1:0]      n_slot;
    logic [FW-1:0]      r_fill;
    logic               r_full;
    logic               n_full;

    logic [31:0]        r_centroid [LABEL_COUNT];
    logic [31:0]        r_offset;
    logic signed [15:0] r_threshold;

    // ring read sequencing
    logic               r_issue;
    logic [AW-1:0]      r_addr;
    logic [RW-1:0]      r_run;
    logic [JW-1:0]      r_j;
    logic               r_t_vld;
    logic               r_t_first;
    logic               r_t_last;
    logic [RW-1:0]      r_t_run;
    logic [31:0]        rd_data;
    logic signed [SW-1:0] r_acc_x;
    logic signed [SW-1:0] r_acc_y;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [SW-1:0] r_sum_x [RUN_COUNT];
    logic signed [SW-1:0] r_sum_y [RUN_COUNT];

    // labelling
    logic               r_liss;
    logic [RW-1:0]      r_lr;
    t_label             r_lk;
    logic               r_lp;
    logic [RW-1:0]      r_wr_run;
    t_label             r_labels [RUN_COUNT];
    t_label_req         l_req;
    t_label_wr          l_wr;
    logic signed [SW-1:0] l_sum;

    logic signed [15:0] sc_like;
    logic               sc_found;
    logic [14:0]        sc_packed;

    logic               r_out_vld;
    logic [39:0]        r_out_data;

    logic               s_acc;
    logic               out_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_vld || i_m_tready;
    assign n_slot      = (r_slot == AW'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
    assign n_full      = (r_fill == FW'(WINDOW_LEN - 1)) || (r_fill == FW'(WINDOW_LEN));

    cgmd_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (s_acc),
        .i_wr_addr (r_slot),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (r_state == S_ACC && r_issue),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    assign sum_x = (r_t_first ? '0 : r_acc_x) + SW'(signed'(rd_data[15:0]));
    assign sum_y = (r_t_first ? '0 : r_acc_y) + SW'(signed'(rd_data[31:16]));

    assign l_req = '{vld: (r_state == S_LABEL) && r_liss, k: r_lk, p: r_lp};
    assign l_sum = r_lp ? r_sum_y[r_lr] : r_sum_x[r_lr];

    cgmd_label #(
        .RUN_LEN (RUN_LEN)
    ) u_label (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (l_req),
        .i_sum      (l_sum),
        .i_centroid (r_centroid),
        .i_offset   (r_offset),
        .o_wr       (l_wr)
    );

    cgmd_score #(
        .RUN_COUNT (RUN_COUNT)
    ) u_score (
        .i_labels    (r_labels),
        .i_threshold (r_threshold),
        .o_like      (sc_like),
        .o_found     (sc_found),
        .o_packed    (sc_packed)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_fill    <= '0;
            r_full    <= 1'b0;
            r_issue   <= 1'b0;
            r_t_vld   <= 1'b0;
            r_liss    <= 1'b0;
            r_wr_run  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_t_vld <= r_state == S_ACC && r_issue;
            if (r_state == S_SCORE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_slot <= n_slot;
                        r_full <= n_full;
                        if (r_fill != FW'(WINDOW_LEN)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        if (n_full) begin
                            r_state <= S_ACC;
                            r_issue <= 1'b1;
                        end else begin
                            r_state <= S_SCORE;
                        end
                    end
                end
                S_ACC: begin
                    if (r_issue && r_run == RW'(RUN_COUNT - 1) && r_j == JW'(RUN_LEN - 1)) begin
                        r_issue <= 1'b0;
                    end
                    if (r_t_vld && r_t_last && r_t_run == RW'(RUN_COUNT - 1)) begin
                        r_state <= S_LABEL;
                        r_liss  <= 1'b1;
                    end
                end
                S_LABEL: begin
                    if (r_liss && r_lp && r_lk == LAST_LABEL && r_lr == RW'(RUN_COUNT - 1)) begin
                        r_liss <= 1'b0;
                    end
                    if (l_wr.vld) begin
                        if (r_wr_run == RW'(RUN_COUNT - 1)) begin
                            r_wr_run <= '0;
                            r_state  <= S_SCORE;
                        end else begin
                            r_wr_run <= r_wr_run + 1'b1;
                        end
                    end
                end
                S_SCORE: begin
                    if (out_free) begin
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LABEL_COUNT; k++) begin
                r_centroid[k] <= '0;
            end
            r_offset    <= OFFSET_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTROID_ZERO, CFG_CENTROID_ONE, CFG_CENTROID_TWO,
                CFG_CENTROID_THREE, CFG_CENTROID_FOUR: begin
                    r_centroid[i_cfg_index] <= i_cfg_data;
                end
                CFG_OFFSET: begin
                    r_offset <= i_cfg_data;
                end
                CFG_THRESHOLD: begin
                    r_threshold <= signed'(i_cfg_data[15:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_addr <= n_slot;
            r_run  <= '0;
            r_j    <= '0;
        end else if (r_state == S_ACC && r_issue) begin
            r_addr <= (r_addr == AW'(WINDOW_LEN - 1)) ? '0 : r_addr + 1'b1;
            if (r_j == JW'(RUN_LEN - 1)) begin
                r_j   <= '0;
                r_run <= r_run + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        r_t_first <= (r_j == '0);
        r_t_last  <= (r_j == JW'(RUN_LEN - 1));
        r_t_run   <= r_run;
        if (r_t_vld) begin
            r_acc_x <= sum_x;
            r_acc_y <= sum_y;
            if (r_t_last) begin
                r_sum_x[r_t_run] <= sum_x;
                r_sum_y[r_t_run] <= sum_y;
            end
        end

        if (r_state == S_ACC) begin
            r_lr <= '0;
            r_lk <= '0;
            r_lp <= 1'b0;
        end else if (l_req.vld) begin
            r_lp <= !r_lp;
            if (r_lp) begin
                if (r_lk == LAST_LABEL) begin
                    r_lk <= '0;
                    r_lr <= r_lr + 1'b1;
                end else begin
                    r_lk <= r_lk + 1'b1;
                end
            end
        end
        if (l_wr.vld) begin
            r_labels[r_wr_run] <= l_wr.label;
        end

        if (r_state == S_SCORE && out_free) begin
            if (r_full) begin
                r_out_data <= {7'd0, sc_packed, sc_like, 1'b1, sc_found};
            end else begin
                r_out_data <= {7'd0, 15'd0, NO_GESTURE, 1'b0, 1'b0};
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== rtl/core/cgmd_checker.sv =====
module cgmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata
);

    // stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result dropped while stalled");

    // a circle needs a full window and a first label of three
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[0] |-> i_m_tdata[1] && i_m_tdata[20:18] == 3'd3
            && i_m_tdata[17:2] != 16'h8000)
        else $error("circle reported without its preconditions");

    // partial window reports the no-gesture value and no labels
    a_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tdata[1] |-> i_m_tdata[17:2] == 16'h8000
            && i_m_tdata[32:18] == 15'd0 && !i_m_tdata[0])
        else $error("partial window result not empty");

    // padding stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[39:33] == 7'd0)
        else $error("padding bits set");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

endmodule

bind circle_gesture_markov_detector cgmd_checker u_cgmd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
